FILE: rtl/core/rvh_pkg.sv
// Shared types and constants of the RV32I hart.
`default_nettype none
package rvh_pkg;

	localparam int CSR_COUNT = 4096;
	localparam int CSR_BITS  = 12;

	localparam logic [6:0] OP_REG    = 7'h33;
	localparam logic [6:0] OP_IMM    = 7'h13;
	localparam logic [6:0] OP_LOAD   = 7'h03;
	localparam logic [6:0] OP_STORE  = 7'h23;
	localparam logic [6:0] OP_BRANCH = 7'h63;
	localparam logic [6:0] OP_SYSTEM = 7'h73;
	localparam logic [6:0] OP_JAL    = 7'h6F;
	localparam logic [6:0] OP_JALR   = 7'h67;
	localparam logic [6:0] OP_LUI    = 7'h37;
	localparam logic [6:0] OP_AUIPC  = 7'h17;
	localparam logic [6:0] F7_ALT    = 7'h20;

	localparam logic [11:0] F12_ECALL  = 12'h000;
	localparam logic [11:0] F12_EBREAK = 12'h001;
	localparam logic [11:0] F12_MRET   = 12'h302;

	localparam logic [11:0] CSR_MSTATUS = 12'h300;
	localparam logic [11:0] CSR_MTVEC   = 12'h305;
	localparam logic [11:0] CSR_MEPC    = 12'h341;
	localparam logic [11:0] CSR_MCAUSE  = 12'h342;

	localparam logic [31:0] UPPER_MASK    = 32'hFFFFF000;
	localparam logic [31:0] CAUSE_ILLEGAL = 32'd2;
	localparam logic [31:0] CAUSE_BREAK   = 32'd3;
	localparam logic [31:0] CAUSE_ECALL   = 32'd11;

	localparam logic [1:0] SIZE_BYTE = 2'd0;
	localparam logic [1:0] SIZE_HALF = 2'd1;
	localparam logic [1:0] SIZE_WORD = 2'd2;

	typedef enum logic [1:0] {
		TRAP_NONE    = 2'd0,
		TRAP_ILLEGAL = 2'd1,
		TRAP_BREAK   = 2'd2,
		TRAP_ECALL   = 2'd3
	} trap_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOAD,
		ST_FETCH,
		ST_RS2,
		ST_EXEC,
		ST_MEMRD
	} state_t;

	typedef struct packed {
		logic clear;
		logic accept;
		logic fetch;
		logic rs2;
		logic mem_t;
		logic load_commit;
		logic exec_commit;
		logic memrd_commit;
	} ctl_cmd_t;

	typedef struct packed {
		logic clr_done;
		logic mode;
		logic is_load;
		logic slot_free;
	} ctl_sts_t;

endpackage
`default_nettype wire

FILE: rtl/core/rvh_if.sv
// Request and response channel interfaces of the hart.
`default_nettype none
interface rvh_req_if;
	logic        valid;
	logic        ready;
	logic        mode;
	logic [15:0] load_address;
	logic [31:0] load_data;
	modport source (output valid, mode, load_address, load_data, input ready);
	modport sink (input valid, mode, load_address, load_data, output ready);
endinterface

interface rvh_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] pc_next;
	logic        reg_written;
	logic [4:0]  reg_index;
	logic [31:0] reg_value;
	logic        mem_written;
	logic [15:0] mem_address;
	logic [31:0] mem_data;
	logic [1:0]  mem_bytes;
	logic [1:0]  trap_kind;
	modport source (output valid, pc_next, reg_written, reg_index, reg_value, mem_written,
		mem_address, mem_data, mem_bytes, trap_kind, input ready);
	modport sink (input valid, pc_next, reg_written, reg_index, reg_value, mem_written,
		mem_address, mem_data, mem_bytes, trap_kind, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/rvh_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module rvh_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule
`default_nettype wire

FILE: rtl/core/rvh_ctrl.sv
// Sequencer of the hart: clear sweep, fetch, register read, execute, load.
`default_nettype none
module rvh_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	output logic                    req_ready,
	input  wire rvh_pkg::ctl_sts_t  sts,
	output rvh_pkg::ctl_cmd_t       cmd
);
	rvh_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rvh_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			rvh_pkg::ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (sts.clr_done) begin
					state_d = rvh_pkg::ST_IDLE;
				end
			end
			rvh_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.accept = 1'b1;
					state_d    = sts.mode ? rvh_pkg::ST_FETCH : rvh_pkg::ST_LOAD;
				end
			end
			rvh_pkg::ST_LOAD: begin
				if (sts.slot_free) begin
					cmd.load_commit = 1'b1;
					state_d         = rvh_pkg::ST_IDLE;
				end
			end
			rvh_pkg::ST_FETCH: begin
				cmd.fetch = 1'b1;
				state_d   = rvh_pkg::ST_RS2;
			end
			rvh_pkg::ST_RS2: begin
				cmd.rs2 = 1'b1;
				state_d = rvh_pkg::ST_EXEC;
			end
			rvh_pkg::ST_EXEC: begin
				if (sts.is_load) begin
					cmd.mem_t = 1'b1;
					state_d   = rvh_pkg::ST_MEMRD;
				end else if (sts.slot_free) begin
					cmd.exec_commit = 1'b1;
					state_d         = rvh_pkg::ST_IDLE;
				end
			end
			rvh_pkg::ST_MEMRD: begin
				cmd.mem_t = 1'b1;
				if (sts.slot_free) begin
					cmd.memrd_commit = 1'b1;
					state_d          = rvh_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = rvh_pkg::ST_CLEAR;
			end
		endcase
	end
endmodule
`default_nettype wire

FILE: rtl/core/rvh_datapath.sv
// Datapath of the hart: memories, registers, decode, ALU and result register.
`default_nettype none
module rvh_datapath #(
	parameter int MEM_BYTES = 65536
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire rvh_pkg::ctl_cmd_t cmd,
	output rvh_pkg::ctl_sts_t      sts,
	input  wire logic              cfg_we,
	input  wire logic [31:0]       cfg_wdata,
	input  wire logic              mode,
	input  wire logic [15:0]       load_address,
	input  wire logic [31:0]       load_data,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [31:0]            pc_next,
	output logic                   reg_written,
	output logic [4:0]             reg_index,
	output logic [31:0]            reg_value,
	output logic                   mem_written,
	output logic [15:0]            mem_address,
	output logic [31:0]            mem_data,
	output logic [1:0]             mem_bytes,
	output logic [1:0]             trap_kind
);
	localparam int ADDR_BITS = $clog2(MEM_BYTES);
	localparam int ROWS      = MEM_BYTES / 4;
	localparam int ROW_BITS  = ADDR_BITS - 2;
	localparam int CLR_DEPTH = (ROWS > rvh_pkg::CSR_COUNT) ? ROWS : rvh_pkg::CSR_COUNT;
	localparam int CLR_BITS  = $clog2(CLR_DEPTH);
	localparam logic [CLR_BITS-1:0] CLR_LAST = CLR_BITS'(CLR_DEPTH - 1);

	logic [CLR_BITS-1:0] clr_cnt_q;
	logic [31:0] start_pc_q, pc_q;
	logic [15:0] laddr_q;
	logic [31:0] ldata_q, ins_q, a_q;
	logic [31:0] mstatus_q, mtvec_q, mepc_q, mcause_q;
	logic        out_valid_q;

	logic [7:0]  lane_rdata [4];
	logic [31:0] rf_rdata, csr_rdata, rword;

	// decode
	logic [6:0]  op, f7;
	logic [4:0]  rd, rs1;
	logic [2:0]  f3;
	logic [11:0] csr_idx;
	logic [31:0] a, b, ii, imm_s, imm_b, imm_j, addr_t;
	logic [ADDR_BITS-1:0] t_w, pc_w, la_w, wa_w, ra_w;

	assign op      = ins_q[6:0];
	assign rd      = ins_q[11:7];
	assign f3      = ins_q[14:12];
	assign rs1     = ins_q[19:15];
	assign f7      = ins_q[31:25];
	assign csr_idx = ins_q[31:20];
	assign a       = a_q;
	assign b       = rf_rdata;
	assign ii      = {{20{ins_q[31]}}, ins_q[31:20]};
	assign imm_s   = {{20{ins_q[31]}}, ins_q[31:25], ins_q[11:7]};
	assign imm_b   = {{19{ins_q[31]}}, ins_q[31], ins_q[7], ins_q[30:25], ins_q[11:8], 1'b0};
	assign imm_j   = {{11{ins_q[31]}}, ins_q[31], ins_q[19:12], ins_q[20], ins_q[30:21], 1'b0};
	assign addr_t  = a + ((op == rvh_pkg::OP_STORE) ? imm_s : ii);
	assign t_w     = addr_t[ADDR_BITS-1:0];
	assign pc_w    = pc_q[ADDR_BITS-1:0];

	logic [31:0] la32;
	assign la32 = {16'b0, laddr_q};
	assign la_w = la32[ADDR_BITS-1:0];
	assign wa_w = cmd.load_commit ? la_w : t_w;
	assign ra_w = cmd.mem_t ? t_w : pc_w;

	function automatic logic [31:0] alu(input logic [2:0] fn, input logic alt,
		input logic [31:0] x, input logic [31:0] y);
		logic [4:0] s;
		s = y[4:0];
		case (fn)
			3'd0: alu = alt ? x - y : x + y;
			3'd1: alu = x << s;
			3'd2: alu = {31'b0, $signed(x) < $signed(y)};
			3'd3: alu = {31'b0, x < y};
			3'd4: alu = x ^ y;
			3'd5: alu = alt ? 32'($signed(x) >>> s) : x >> s;
			3'd6: alu = x | y;
			default: alu = x & y;
		endcase
	endfunction

	// CSR current value, with the trap CSRs held in flops
	logic        csr_special;
	logic [31:0] cur;
	always_comb begin
		csr_special = 1'b1;
		case (csr_idx)
			rvh_pkg::CSR_MSTATUS: cur = mstatus_q;
			rvh_pkg::CSR_MTVEC:   cur = mtvec_q;
			rvh_pkg::CSR_MEPC:    cur = mepc_q;
			rvh_pkg::CSR_MCAUSE:  cur = mcause_q;
			default: begin
				cur         = csr_rdata;
				csr_special = 1'b0;
			end
		endcase
	end

	// execute
	logic          ex_wr, ex_store, ex_csr_we, ex_mret, ld_ok;
	logic [31:0]   ex_rdv, ex_nxt, ex_csr_wdata, ex_mdata, csr_src;
	rvh_pkg::trap_t ex_trap;
	logic          take;

	always_comb begin
		ex_wr        = 1'b0;
		ex_store     = 1'b0;
		ex_csr_we    = 1'b0;
		ex_mret      = 1'b0;
		ex_rdv       = '0;
		ex_nxt       = pc_q + 32'd4;
		ex_csr_wdata = '0;
		ex_mdata     = '0;
		ex_trap      = rvh_pkg::TRAP_NONE;
		take         = 1'b0;
		ld_ok        = 1'b0;
		csr_src      = f3[2] ? {27'b0, rs1} : a;
		case (op)
			rvh_pkg::OP_REG: begin
				if (f7 == 7'd0 || (f7 == rvh_pkg::F7_ALT && (f3 == 3'd0 || f3 == 3'd5))) begin
					ex_rdv = alu(f3, f7 == rvh_pkg::F7_ALT, a, b);
					ex_wr  = 1'b1;
				end else begin
					ex_trap = rvh_pkg::TRAP_ILLEGAL;
				end
			end
			rvh_pkg::OP_IMM: begin
				if ((f3 == 3'd1 && f7 != 7'd0) ||
					(f3 == 3'd5 && f7 != 7'd0 && f7 != rvh_pkg::F7_ALT)) begin
					ex_trap = rvh_pkg::TRAP_ILLEGAL;
				end else begin
					ex_rdv = alu(f3, f3 == 3'd5 && f7 == rvh_pkg::F7_ALT, a, ii);
					ex_wr  = 1'b1;
				end
			end
			rvh_pkg::OP_LOAD: begin
				if (f3 == 3'd0 || f3 == 3'd1 || f3 == 3'd2 || f3 == 3'd4 || f3 == 3'd5) begin
					ld_ok = 1'b1;
				end else begin
					ex_trap = rvh_pkg::TRAP_ILLEGAL;
				end
			end
			rvh_pkg::OP_STORE: begin
				if (f3 > 3'd2) begin
					ex_trap = rvh_pkg::TRAP_ILLEGAL;
				end else begin
					ex_store = 1'b1;
					case (f3[1:0])
						rvh_pkg::SIZE_BYTE: ex_mdata = {24'b0, b[7:0]};
						rvh_pkg::SIZE_HALF: ex_mdata = {16'b0, b[15:0]};
						default:            ex_mdata = b;
					endcase
				end
			end
			rvh_pkg::OP_BRANCH: begin
				case (f3)
					3'd0: take = a == b;
					3'd1: take = a != b;
					3'd4: take = $signed(a) < $signed(b);
					3'd5: take = !($signed(a) < $signed(b));
					3'd6: take = a < b;
					3'd7: take = a >= b;
					default: ex_trap = rvh_pkg::TRAP_ILLEGAL;
				endcase
				if (take) begin
					ex_nxt = pc_q + imm_b;
				end
			end
			rvh_pkg::OP_JAL: begin
				ex_rdv = pc_q + 32'd4;
				ex_wr  = 1'b1;
				ex_nxt = pc_q + imm_j;
			end
			rvh_pkg::OP_JALR: begin
				if (f3 != 3'd0) begin
					ex_trap = rvh_pkg::TRAP_ILLEGAL;
				end else begin
					ex_rdv = pc_q + 32'd4;
					ex_wr  = 1'b1;
					ex_nxt = (a + ii) & ~32'd1;
				end
			end
			rvh_pkg::OP_LUI: begin
				ex_rdv = ins_q & rvh_pkg::UPPER_MASK;
				ex_wr  = 1'b1;
			end
			rvh_pkg::OP_AUIPC: begin
				ex_rdv = pc_q + (ins_q & rvh_pkg::UPPER_MASK);
				ex_wr  = 1'b1;
			end
			rvh_pkg::OP_SYSTEM: begin
				if (f3 == 3'd0) begin
					case (csr_idx)
						rvh_pkg::F12_ECALL:  ex_trap = rvh_pkg::TRAP_ECALL;
						rvh_pkg::F12_EBREAK: ex_trap = rvh_pkg::TRAP_BREAK;
						rvh_pkg::F12_MRET: begin
							ex_mret = 1'b1;
							ex_nxt  = mepc_q;
						end
						default: ex_trap = rvh_pkg::TRAP_ILLEGAL;
					endcase
				end else if (f3 == 3'd4) begin
					ex_trap = rvh_pkg::TRAP_ILLEGAL;
				end else begin
					case (f3[1:0])
						2'd1:    ex_csr_wdata = csr_src;
						2'd2:    ex_csr_wdata = cur | csr_src;
						default: ex_csr_wdata = cur & ~csr_src;
					endcase
					ex_csr_we = 1'b1;
					ex_rdv    = cur;
					ex_wr     = 1'b1;
				end
			end
			default: ex_trap = rvh_pkg::TRAP_ILLEGAL;
		endcase
	end

	logic ex_ok;
	assign ex_ok = (ex_trap == rvh_pkg::TRAP_NONE);

	logic [31:0] trap_cause;
	always_comb begin
		case (ex_trap)
			rvh_pkg::TRAP_BREAK: trap_cause = rvh_pkg::CAUSE_BREAK;
			rvh_pkg::TRAP_ECALL: trap_cause = rvh_pkg::CAUSE_ECALL;
			default:             trap_cause = rvh_pkg::CAUSE_ILLEGAL;
		endcase
	end

	// byte lanes
	logic [1:0]  wr_size;
	logic [31:0] wsrc;
	logic        lane_commit;
	assign wr_size     = cmd.load_commit ? rvh_pkg::SIZE_WORD : f3[1:0];
	assign wsrc        = cmd.load_commit ? ldata_q : b;
	assign lane_commit = cmd.load_commit | (cmd.exec_commit & ex_store & ex_ok);

	for (genvar k = 0; k < 4; k++) begin : g_lane
		localparam logic [1:0] LANE = 2'(k);
		logic [1:0]          wi;
		logic                wen, lwe;
		logic [ROW_BITS-1:0] wrow, rrow, lwaddr;
		logic [7:0]          lwdata;

		assign wi   = LANE - wa_w[1:0];
		assign wen  = (wr_size == rvh_pkg::SIZE_WORD) ||
			(wr_size == rvh_pkg::SIZE_HALF && !wi[1]) || (wi == 2'd0);
		assign wrow = wa_w[ADDR_BITS-1:2] + {{(ROW_BITS-1){1'b0}}, LANE < wa_w[1:0]};
		assign rrow = ra_w[ADDR_BITS-1:2] + {{(ROW_BITS-1){1'b0}}, LANE < ra_w[1:0]};
		assign lwe    = cmd.clear | (lane_commit & wen);
		assign lwaddr = cmd.clear ? clr_cnt_q[ROW_BITS-1:0] : wrow;
		assign lwdata = cmd.clear ? 8'd0 : wsrc[8*wi +: 8];

		rvh_ram #(.WIDTH(8), .DEPTH(ROWS)) u_lane (
			.clk   (clk),
			.we    (lwe),
			.waddr (lwaddr),
			.wdata (lwdata),
			.raddr (rrow),
			.rdata (lane_rdata[k])
		);
	end

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			rword[8*i +: 8] = lane_rdata[2'(ra_w[1:0] + 2'(i))];
		end
	end

	// register file
	logic       rf_we;
	logic [4:0] rf_waddr, rf_raddr;
	logic [31:0] rf_wdata, ld_val;

	always_comb begin
		case (f3)
			3'd0:    ld_val = {{24{rword[7]}}, rword[7:0]};
			3'd1:    ld_val = {{16{rword[15]}}, rword[15:0]};
			3'd4:    ld_val = {24'b0, rword[7:0]};
			3'd5:    ld_val = {16'b0, rword[15:0]};
			default: ld_val = rword;
		endcase
	end

	logic ex_rf_we;
	assign ex_rf_we = ex_wr & ex_ok & (rd != 5'd0);
	assign rf_raddr = cmd.fetch ? rword[19:15] : ins_q[24:20];
	always_comb begin
		rf_we    = 1'b0;
		rf_waddr = rd;
		rf_wdata = ex_rdv;
		if (cmd.clear) begin
			rf_we    = 1'b1;
			rf_waddr = clr_cnt_q[4:0];
			rf_wdata = '0;
		end else if (cmd.exec_commit) begin
			rf_we = ex_rf_we;
		end else if (cmd.memrd_commit) begin
			rf_we    = rd != 5'd0;
			rf_wdata = ld_val;
		end
	end

	rvh_ram #(.WIDTH(32), .DEPTH(32)) u_rf (
		.clk   (clk),
		.we    (rf_we),
		.waddr (rf_waddr),
		.wdata (rf_wdata),
		.raddr (rf_raddr),
		.rdata (rf_rdata)
	);

	// CSR file
	logic                          csr_we;
	logic [rvh_pkg::CSR_BITS-1:0]  csr_waddr, csr_raddr;
	logic [31:0]                   csr_wdata;
	assign csr_raddr = cmd.fetch ? rword[31:20] : ins_q[31:20];
	assign csr_we    = cmd.clear | (cmd.exec_commit & ex_ok & ex_csr_we & !csr_special);
	assign csr_waddr = cmd.clear ? clr_cnt_q[rvh_pkg::CSR_BITS-1:0] : csr_idx;
	assign csr_wdata = cmd.clear ? 32'd0 : ex_csr_wdata;

	rvh_ram #(.WIDTH(32), .DEPTH(rvh_pkg::CSR_COUNT)) u_csr (
		.clk   (clk),
		.we    (csr_we),
		.waddr (csr_waddr),
		.wdata (csr_wdata),
		.raddr (csr_raddr),
		.rdata (csr_rdata)
	);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q   <= '0;
			start_pc_q  <= '0;
			pc_q        <= '0;
			mstatus_q   <= '0;
			mtvec_q     <= '0;
			mepc_q      <= '0;
			mcause_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clear && clr_cnt_q != CLR_LAST) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
			if (cfg_we) begin
				start_pc_q <= cfg_wdata;
			end
			if (cmd.load_commit) begin
				pc_q <= start_pc_q;
			end
			if (cmd.memrd_commit) begin
				pc_q <= pc_q + 32'd4;
			end
			if (cmd.exec_commit) begin
				if (!ex_ok) begin
					pc_q      <= mtvec_q;
					mepc_q    <= pc_q;
					mcause_q  <= trap_cause;
					mstatus_q <= {mstatus_q[31:8], mstatus_q[3], mstatus_q[6:4], 1'b0,
						mstatus_q[2:0]};
				end else begin
					pc_q <= ex_nxt;
					if (ex_mret) begin
						mstatus_q <= {mstatus_q[31:8], 1'b1, mstatus_q[6:4], mstatus_q[7],
							mstatus_q[2:0]};
					end
					if (ex_csr_we) begin
						case (csr_idx)
							rvh_pkg::CSR_MSTATUS: mstatus_q <= ex_csr_wdata;
							rvh_pkg::CSR_MTVEC:   mtvec_q   <= ex_csr_wdata;
							rvh_pkg::CSR_MEPC:    mepc_q    <= ex_csr_wdata;
							rvh_pkg::CSR_MCAUSE:  mcause_q  <= ex_csr_wdata;
							default: ;
						endcase
					end
				end
			end
			if (cmd.load_commit || cmd.exec_commit || cmd.memrd_commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	logic [31:0] wa32;
	assign wa32 = 32'(wa_w);

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			laddr_q <= load_address;
			ldata_q <= load_data;
		end
		if (cmd.fetch) begin
			ins_q <= rword;
		end
		if (cmd.rs2) begin
			a_q <= rf_rdata;
		end
		if (cmd.load_commit) begin
			pc_next     <= start_pc_q;
			reg_written <= 1'b0;
			reg_index   <= '0;
			reg_value   <= '0;
			mem_written <= 1'b1;
			mem_address <= wa32[15:0];
			mem_data    <= ldata_q;
			mem_bytes   <= rvh_pkg::SIZE_WORD;
			trap_kind   <= rvh_pkg::TRAP_NONE;
		end
		if (cmd.exec_commit) begin
			pc_next     <= ex_ok ? ex_nxt : mtvec_q;
			reg_written <= ex_rf_we;
			reg_index   <= ex_rf_we ? rd : 5'd0;
			reg_value   <= ex_rf_we ? ex_rdv : 32'd0;
			mem_written <= ex_store & ex_ok;
			mem_address <= (ex_store & ex_ok) ? wa32[15:0] : 16'd0;
			mem_data    <= (ex_store & ex_ok) ? ex_mdata : 32'd0;
			mem_bytes   <= (ex_store & ex_ok) ? f3[1:0] : 2'd0;
			trap_kind   <= ex_trap;
		end
		if (cmd.memrd_commit) begin
			pc_next     <= pc_q + 32'd4;
			reg_written <= rd != 5'd0;
			reg_index   <= rd;
			reg_value   <= (rd != 5'd0) ? ld_val : 32'd0;
			mem_written <= 1'b0;
			mem_address <= '0;
			mem_data    <= '0;
			mem_bytes   <= '0;
			trap_kind   <= rvh_pkg::TRAP_NONE;
		end
	end

	assign out_valid     = out_valid_q;
	assign sts.clr_done  = clr_cnt_q == CLR_LAST;
	assign sts.mode      = mode;
	assign sts.is_load   = ld_ok;
	assign sts.slot_free = !out_valid_q || out_ready;
endmodule
`default_nettype wire

FILE: rtl/core/rv32i_hart_step.sv
// Top level of the multicycle RV32I machine-mode hart.
`default_nettype none
// After reset the hart runs a clearing pass that zeroes memory, registers and CSRs; no
// request is taken until it ends, while start_pc writes are taken at any time. A
// program-load request passes through a load state; an instruction step goes through
// idle/fetch, operand A read, operand B read and execute, and a memory load adds a memory
// read state, since the register file and memory each have one registered read port.
// A result waits in an output register; the next request is taken meanwhile. MEM_BYTES
// must be a power of two; the block itself does not enforce it.
module rv32i_hart_step #(
	parameter int MEM_BYTES = 65536
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	rvh_req_if.sink    req,
	rvh_rsp_if.source  rsp,
	input  wire logic  cfg_we,
	input  wire logic [31:0] cfg_wdata
);
	rvh_pkg::ctl_cmd_t cmd;
	rvh_pkg::ctl_sts_t sts;

	rvh_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	rvh_datapath #(.MEM_BYTES(MEM_BYTES)) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.mode         (req.mode),
		.load_address (req.load_address),
		.load_data    (req.load_data),
		.out_valid    (rsp.valid),
		.out_ready    (rsp.ready),
		.pc_next      (rsp.pc_next),
		.reg_written  (rsp.reg_written),
		.reg_index    (rsp.reg_index),
		.reg_value    (rsp.reg_value),
		.mem_written  (rsp.mem_written),
		.mem_address  (rsp.mem_address),
		.mem_data     (rsp.mem_data),
		.mem_bytes    (rsp.mem_bytes),
		.trap_kind    (rsp.trap_kind)
	);
endmodule
`default_nettype wire

FILE: tb/tb_rv32i_hart_step.sv
// Self-checking testbench of the RV32I hart: random programs against a built-in hart predictor.
`default_nettype none
module tb_rv32i_hart_step;
	import rvh_pkg::*;

	typedef struct packed {
		logic        mode;
		logic [15:0] load_address;
		logic [31:0] load_data;
	} hart_req_t;

	typedef struct packed {
		logic [31:0] pc_next;
		logic        reg_written;
		logic [4:0]  reg_index;
		logic [31:0] reg_value;
		logic        mem_written;
		logic [15:0] mem_address;
		logic [31:0] mem_data;
		logic [1:0]  mem_bytes;
		trap_t       trap_kind;
	} hart_rsp_t;

	localparam int MDL_BYTES = 65536;
	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_STEP = 1'b1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [31:0] cfg_wdata = '0;

	rvh_req_if req_ch();
	rvh_rsp_if rsp_ch();

	rv32i_hart_step u_top (
		.clk(clk), .arst_n(arst_n), .req(req_ch), .rsp(rsp_ch),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	hart_req_t pending_q[$];
	hart_rsp_t expected_q[$];
	int errors = 0;
	int req_gap = 0;
	int rsp_gap = 0;
	int choke_left = 0;
	bit req_taken = 0;
	bit calm = 0;

	logic [7:0]  mdl_mem[MDL_BYTES];
	logic [31:0] mdl_x[32];
	logic [31:0] mdl_csr[CSR_COUNT];
	logic [31:0] mdl_pc;
	logic [31:0] mdl_start;

	function automatic logic [31:0] sx(logic [31:0] v, int n);
		logic signed [31:0] s;
		s = v << (32 - n);
		return s >>> (32 - n);
	endfunction

	function automatic logic [31:0] mem_rd(logic [31:0] a, int n);
		logic [31:0] v;
		v = '0;
		for (int i = 0; i < n; i++)
			v |= 32'(mdl_mem[(a + i) % MDL_BYTES]) << (8 * i);
		return v;
	endfunction

	function automatic void mem_wr(logic [31:0] a, logic [31:0] v, int n);
		for (int i = 0; i < n; i++)
			mdl_mem[(a + i) % MDL_BYTES] = v[8*i +: 8];
	endfunction

	function automatic logic [31:0] alu_op(logic [2:0] f3, bit alt, logic [31:0] a,
		logic [31:0] b);
		case (f3)
			3'd0: return alt ? a - b : a + b;
			3'd1: return a << b[4:0];
			3'd2: return ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
			3'd3: return (a < b) ? 32'd1 : 32'd0;
			3'd4: return a ^ b;
			3'd5: return alt ? 32'($signed(a) >>> b[4:0]) : a >> b[4:0];
			3'd6: return a | b;
			default: return a & b;
		endcase
	endfunction

	function automatic hart_rsp_t step_hart(hart_req_t it);
		hart_rsp_t r;
		logic [31:0] ins, a, b, ii, nxt, t, rdv, cause, ms, cur, src;
		logic [6:0] op, f7;
		logic [4:0] rd;
		logic [2:0] f3;
		logic [11:0] ci;
		bit wr, take, trapped;
		r = '0;
		if (it.mode == MODE_LOAD) begin
			mem_wr(32'(it.load_address), it.load_data, 4);
			mdl_pc = mdl_start;
			r.pc_next = mdl_pc;
			r.mem_written = 1'b1;
			r.mem_address = it.load_address;
			r.mem_data = it.load_data;
			r.mem_bytes = SIZE_WORD;
			return r;
		end
		ins = mem_rd(mdl_pc, 4);
		op = ins[6:0];
		rd = ins[11:7];
		f3 = ins[14:12];
		f7 = ins[31:25];
		a = mdl_x[ins[19:15]];
		b = mdl_x[ins[24:20]];
		ii = sx(ins >> 20, 12);
		nxt = mdl_pc + 4;
		rdv = '0;
		wr = 0;
		cause = '0;
		case (op)
			OP_REG:
				if (f7 == 0 || (f7 == F7_ALT && (f3 == 0 || f3 == 5))) begin
					rdv = alu_op(f3, f7 == F7_ALT, a, b);
					wr = 1;
				end else cause = CAUSE_ILLEGAL;
			OP_IMM:
				if ((f3 == 1 && f7 != 0) || (f3 == 5 && f7 != 0 && f7 != F7_ALT))
					cause = CAUSE_ILLEGAL;
				else begin
					rdv = alu_op(f3, f3 == 5 && f7 == F7_ALT, a, ii);
					wr = 1;
				end
			OP_LOAD: begin
				t = a + ii;
				wr = 1;
				case (f3)
					3'd0: rdv = sx(mem_rd(t, 1), 8);
					3'd1: rdv = sx(mem_rd(t, 2), 16);
					3'd2: rdv = mem_rd(t, 4);
					3'd4: rdv = mem_rd(t, 1);
					3'd5: rdv = mem_rd(t, 2);
					default: begin wr = 0; cause = CAUSE_ILLEGAL; end
				endcase
			end
			OP_STORE:
				if (f3 > 2) cause = CAUSE_ILLEGAL;
				else begin
					t = (a + sx({ins[31:25], ins[11:7]}, 12)) % MDL_BYTES;
					r.mem_data = (f3 == SIZE_WORD) ? b :
						(f3 == SIZE_HALF) ? (b & 32'hFFFF) : (b & 32'hFF);
					mem_wr(t, r.mem_data, 1 << f3);
					r.mem_address = t[15:0];
					r.mem_bytes = f3[1:0];
					r.mem_written = 1'b1;
				end
			OP_BRANCH: begin
				take = 0;
				case (f3)
					3'd0: take = a == b;
					3'd1: take = a != b;
					3'd4: take = $signed(a) < $signed(b);
					3'd5: take = !($signed(a) < $signed(b));
					3'd6: take = a < b;
					3'd7: take = a >= b;
					default: cause = CAUSE_ILLEGAL;
				endcase
				if (take)
					nxt = mdl_pc + sx({ins[31], ins[7], ins[30:25], ins[11:8], 1'b0}, 13);
			end
			OP_JAL: begin
				rdv = mdl_pc + 4;
				wr = 1;
				nxt = mdl_pc + sx({ins[31], ins[19:12], ins[20], ins[30:21], 1'b0}, 21);
			end
			OP_JALR:
				if (f3 != 0) cause = CAUSE_ILLEGAL;
				else begin
					rdv = mdl_pc + 4;
					wr = 1;
					nxt = (a + ii) & ~32'd1;
				end
			OP_LUI: begin rdv = ins & UPPER_MASK; wr = 1; end
			OP_AUIPC: begin rdv = mdl_pc + (ins & UPPER_MASK); wr = 1; end
			OP_SYSTEM: begin
				ci = ins[31:20];
				cur = mdl_csr[ci];
				src = f3[2] ? 32'(ins[19:15]) : a;
				if (f3 == 0) begin
					if (ci == F12_ECALL) cause = CAUSE_ECALL;
					else if (ci == F12_EBREAK) cause = CAUSE_BREAK;
					else if (ci == F12_MRET) begin
						ms = mdl_csr[CSR_MSTATUS];
						nxt = mdl_csr[CSR_MEPC];
						ms[3] = ms[7];
						ms[7] = 1'b1;
						mdl_csr[CSR_MSTATUS] = ms;
					end else cause = CAUSE_ILLEGAL;
				end else if (f3 == 4) cause = CAUSE_ILLEGAL;
				else begin
					case (f3[1:0])
						2'd1: mdl_csr[ci] = src;
						2'd2: mdl_csr[ci] = cur | src;
						default: mdl_csr[ci] = cur & ~src;
					endcase
					rdv = cur;
					wr = 1;
				end
			end
			default: cause = CAUSE_ILLEGAL;
		endcase
		trapped = cause != 0;
		if (trapped) begin
			ms = mdl_csr[CSR_MSTATUS];
			mdl_csr[CSR_MEPC] = mdl_pc;
			mdl_csr[CSR_MCAUSE] = cause;
			ms[7] = ms[3];
			ms[3] = 1'b0;
			mdl_csr[CSR_MSTATUS] = ms;
			mdl_pc = mdl_csr[CSR_MTVEC];
			r.trap_kind = (cause == CAUSE_ILLEGAL) ? TRAP_ILLEGAL :
				(cause == CAUSE_BREAK) ? TRAP_BREAK : TRAP_ECALL;
		end else begin
			mdl_pc = nxt;
			if (wr && rd != 0) begin
				mdl_x[rd] = rdv;
				r.reg_written = 1'b1;
				r.reg_index = rd;
				r.reg_value = rdv;
			end
		end
		r.pc_next = mdl_pc;
		return r;
	endfunction

	task automatic report(string field, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %h expected %h at %0t", field, got, want, $realtime);
		errors++;
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55) return 0;
		if (r < 88) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// accept transfers, predict, and check results
	always @(posedge clk) begin
		hart_rsp_t want;
		if (arst_n && req_ch.valid && req_ch.ready) begin
			expected_q.push_back(step_hart(pending_q.pop_front()));
			req_taken = 1;
		end
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (expected_q.size() == 0) begin
				report("unexpected transfer", rsp_ch.pc_next, 32'd0);
			end else begin
				want = expected_q.pop_front();
				if (rsp_ch.pc_next !== want.pc_next)
					report("pc_next", rsp_ch.pc_next, want.pc_next);
				if (rsp_ch.reg_written !== want.reg_written)
					report("reg_written", 32'(rsp_ch.reg_written), 32'(want.reg_written));
				if (rsp_ch.reg_index !== want.reg_index)
					report("reg_index", 32'(rsp_ch.reg_index), 32'(want.reg_index));
				if (rsp_ch.reg_value !== want.reg_value)
					report("reg_value", rsp_ch.reg_value, want.reg_value);
				if (rsp_ch.mem_written !== want.mem_written)
					report("mem_written", 32'(rsp_ch.mem_written), 32'(want.mem_written));
				if (rsp_ch.mem_address !== want.mem_address)
					report("mem_address", 32'(rsp_ch.mem_address), 32'(want.mem_address));
				if (rsp_ch.mem_data !== want.mem_data)
					report("mem_data", rsp_ch.mem_data, want.mem_data);
				if (rsp_ch.mem_bytes !== want.mem_bytes)
					report("mem_bytes", 32'(rsp_ch.mem_bytes), 32'(want.mem_bytes));
				if (rsp_ch.trap_kind !== want.trap_kind)
					report("trap_kind", 32'(rsp_ch.trap_kind), 32'(want.trap_kind));
			end
		end
	end

	// request driver
	always @(negedge clk) begin
		if (req_taken) begin
			req_gap = pick_gap();
			req_taken = 0;
		end
		if (!arst_n) req_ch.valid <= 1'b0;
		else if (req_gap > 0) begin
			req_gap--;
			req_ch.valid <= 1'b0;
		end else if (pending_q.size() > 0) begin
			req_ch.valid <= 1'b1;
			req_ch.mode <= pending_q[0].mode;
			req_ch.load_address <= pending_q[0].load_address;
			req_ch.load_data <= pending_q[0].load_data;
		end else req_ch.valid <= 1'b0;
	end

	// result sink
	always @(negedge clk) begin
		if (choke_left > 0) begin
			choke_left--;
			rsp_ch.ready <= 1'b0;
		end else if (rsp_gap > 0) begin
			rsp_gap--;
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= 1'b1;
			rsp_gap = pick_gap();
		end
	end

	function automatic logic [31:0] enc_i(logic [11:0] imm, logic [4:0] rs1, logic [2:0] f3,
		logic [4:0] rd, logic [6:0] op);
		return {imm, rs1, f3, rd, op};
	endfunction

	function automatic logic [31:0] enc_b(logic [12:0] off, logic [2:0] f3, logic [4:0] rs1,
		logic [4:0] rs2);
		return {off[12], off[10:5], rs2, rs1, f3, off[4:1], off[11], OP_BRANCH};
	endfunction

	function automatic logic [31:0] enc_j(logic [20:0] off, logic [4:0] rd);
		return {off[20], off[10:1], off[11], off[19:12], rd, OP_JAL};
	endfunction

	function automatic logic [4:0] pick_rd();
		return 5'($urandom_range(0, 30));
	endfunction

	function automatic logic [11:0] pick_csr();
		case ($urandom_range(0, 5))
			0: return CSR_MSTATUS;
			1: return CSR_MEPC;
			2: return CSR_MCAUSE;
			3: return ($urandom_range(0, 9) == 0) ? CSR_MTVEC : 12'($urandom);
			default: return 12'($urandom);
		endcase
	endfunction

	function automatic logic [31:0] rand_insn(int idx, int len);
		int r;
		logic [31:0] off;
		logic [6:0] f7;
		logic [2:0] f3;
		r = $urandom_range(0, 99);
		off = 32'(($urandom_range(0, len - 1) - idx) * 4);
		f3 = 3'($urandom);
		f7 = ($urandom_range(0, 19) == 0) ? 7'($urandom) : ($urandom_range(0, 1) ? F7_ALT : 7'd0);
		if (r < 20) return {f7, 5'($urandom), 5'($urandom), f3, pick_rd(), OP_REG};
		if (r < 38) begin
			if (f3 == 1 || f3 == 5)
				return enc_i({f7, 5'($urandom)}, 5'($urandom), f3, pick_rd(), OP_IMM);
			return enc_i(12'($urandom), 5'($urandom), f3, pick_rd(), OP_IMM);
		end
		if (r < 48) return enc_i(12'($urandom), 5'($urandom), f3, pick_rd(), OP_LOAD);
		if (r < 58) begin
			off = $urandom;
			return {off[11:5], 5'($urandom), 5'($urandom), 3'($urandom_range(0, 3)), off[4:0],
				OP_STORE};
		end
		if (r < 66) return enc_b(off[12:0], f3, 5'($urandom), 5'($urandom));
		if (r < 70) return enc_j(off[20:0], pick_rd());
		if (r < 74)
			return enc_i(12'(($urandom_range(0, len - 1)) * 4),
				5'd31, ($urandom_range(0, 7) == 0) ? f3 : 3'd0, pick_rd(), OP_JALR);
		if (r < 80)
			return {20'($urandom), pick_rd(), $urandom_range(0, 1) ? OP_LUI : OP_AUIPC};
		if (r < 92) begin
			if (f3 == 0)
				case ($urandom_range(0, 4))
					0: return enc_i(F12_ECALL, 5'd0, 3'd0, 5'd0, OP_SYSTEM);
					1: return enc_i(F12_EBREAK, 5'd0, 3'd0, 5'd0, OP_SYSTEM);
					2: return enc_i(F12_MRET, 5'd0, 3'd0, 5'd0, OP_SYSTEM);
					default: return enc_i(12'($urandom), 5'($urandom), 3'd0, 5'($urandom),
						OP_SYSTEM);
				endcase
			return enc_i(pick_csr(), 5'($urandom), f3, pick_rd(), OP_SYSTEM);
		end
		return $urandom;
	endfunction

	task automatic add_load(logic [31:0] addr, logic [31:0] data);
		pending_q.push_back('{MODE_LOAD, addr[15:0], data});
	endtask

	task automatic add_steps(int n);
		repeat (n) pending_q.push_back('{MODE_STEP, 16'($urandom), $urandom});
	endtask

	task automatic set_start(logic [31:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		mdl_start = v;
	endtask

	task automatic drain();
		wait (pending_q.size() == 0 && expected_q.size() == 0 && !req_ch.valid);
		repeat (8) @(posedge clk);
	endtask

	// point mtvec at the program base held in x31
	task automatic add_prologue(logic [31:0] base);
		logic [31:0] hi;
		hi = base + 32'h800;
		add_load(base, {hi[31:12], 5'd31, OP_LUI});
		add_load(base + 4, enc_i(base[11:0], 5'd31, 3'd0, 5'd31, OP_IMM));
		add_load(base + 8, enc_i(CSR_MTVEC, 5'd31, 3'd1, 5'd0, OP_SYSTEM));
	endtask

	initial begin
		int sent;
		int len;
		bit choked;
		logic [31:0] base;
		logic [31:0] prog[$];
		req_ch.valid = 1'b0;
		req_ch.mode = MODE_LOAD;
		req_ch.load_address = '0;
		req_ch.load_data = '0;
		rsp_ch.ready = 1'b0;
		choked = 0;
		for (int i = 0; i < MDL_BYTES; i++) mdl_mem[i] = '0;
		for (int i = 0; i < 32; i++) mdl_x[i] = '0;
		for (int i = 0; i < CSR_COUNT; i++) mdl_csr[i] = '0;
		mdl_pc = '0;
		mdl_start = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed program at 0x100
		set_start(32'h100);
		prog = '{
			{20'hFFFFF, 5'd1, OP_LUI},
			enc_i(12'hFFF, 5'd0, 3'd0, 5'd2, OP_IMM),
			enc_i(12'h7FF, 5'd0, 3'd0, 5'd3, OP_IMM),
			{7'd0, 5'd2, 5'd1, 3'd0, 5'd4, OP_REG},
			{F7_ALT, 5'd2, 5'd0, 3'd0, 5'd5, OP_REG},
			{F7_ALT, 5'd2, 5'd1, 3'd5, 5'd6, OP_REG},
			{7'd0, 5'd3, 5'd1, 3'd2, 5'd7, OP_REG},
			{7'd0, 5'd3, 5'd1, 3'd3, 5'd8, OP_REG},
			{12'h7FE, 5'd0, 3'd2, 5'd1, OP_STORE},
			enc_i(12'hFFE, 5'd0, 3'd1, 5'd9, OP_LOAD),
			enc_i(12'hFFF, 5'd0, 3'd4, 5'd10, OP_LOAD),
			{7'h7F, 5'd2, 5'd0, 3'd1, 5'h1F, OP_STORE},
			enc_b(13'h8, 3'd1, 5'd1, 5'd2),
			32'h0000000F,
			{20'h00000, 5'd0, OP_AUIPC},
			enc_i(12'h0, 5'd0, 3'd2, 5'd11, OP_LOAD),
			enc_i(CSR_MTVEC, 5'd3, 3'd1, 5'd12, OP_SYSTEM),
			enc_i(CSR_MSTATUS, 5'd8, 3'd6, 5'd13, OP_SYSTEM),
			enc_i(F12_ECALL, 5'd0, 3'd0, 5'd0, OP_SYSTEM),
			enc_i(F12_EBREAK, 5'd0, 3'd0, 5'd0, OP_SYSTEM),
			enc_i(F12_MRET, 5'd0, 3'd0, 5'd0, OP_SYSTEM),
			32'h0000000F,
			enc_j(21'h8, 5'd0)
		};
		foreach (prog[i]) add_load(32'h100 + 4 * i, prog[i]);
		add_load(32'hFFFF, 32'hFFFFFFFF);
		add_load(32'h0, 32'h0);
		add_steps(30);
		drain();

		sent = 0;
		while (sent < 560) begin
			case ($urandom_range(0, 9))
				0: base = 32'h0;
				1: base = 32'hFFFFFFFC;
				2: base = $urandom;
				3: base = {$urandom} | 32'h1;
				default: base = 32'($urandom_range(0, 255)) * 64;
			endcase
			set_start(base);
			calm = ($urandom_range(0, 4) == 0);
			len = $urandom_range(6, 14);
			add_prologue(base);
			for (int i = 3; i < len; i++) add_load(base + 4 * i, rand_insn(i, len));
			if ($urandom_range(0, 3) == 0) add_load($urandom, $urandom);
			add_steps(2 * len + $urandom_range(0, 10));
			sent += 3 * len + 10;
			if (sent > 250 && !choked) begin
				@(posedge clk);
				choke_left = 300;
				choked = 1;
			end
			drain();
		end
		set_start(32'hFFFFFFFF);
		calm = 0;
		add_load(32'hFFFF, 32'h0);
		add_steps(2);
		drain();
		repeat (20) @(posedge clk);
		if (errors == 0 && expected_q.size() == 0)
			$display("** rv32i_hart_step: PASSED **");
		else
			$display("** rv32i_hart_step: FAILED **");
		$finish;
	end

	initial begin
		#3000000;
		$display("** rv32i_hart_step: FAILED **");
		$finish;
	end

endmodule
`default_nettype wire

FILE: rv32i_hart_step.f
rtl/core/rvh_pkg.sv
rtl/core/rvh_if.sv
rtl/core/rvh_ram.sv
rtl/core/rvh_ctrl.sv
rtl/core/rvh_datapath.sv
rtl/core/rv32i_hart_step.sv
tb/tb_rv32i_hart_step.sv
